// File: rtl/core/kdc_pkg.sv
// Shared widths, constants and types of the keyword detect controller.
package kdc_pkg;

  localparam int SMOOTH_DEPTH = 5;
  localparam int CLASS_COUNT  = 64;

  localparam int ENERGY_W   = 38;
  localparam int CLASS_W    = 6;
  localparam int PROB_W     = 16;
  localparam int INTERVAL_W = 8;
  localparam int TIMEOUT_W  = 9;
  localparam int COUNT_W    = 10;
  localparam int MODE_W     = 2;
  localparam int ENTRY_W    = 7;
  localparam int POS_W      = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 38;

  localparam logic [ENTRY_W-1:0] EMPTY_MARK = 7'd127;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam logic [ENERGY_W-1:0]   VAD_RESET      = 38'd171798691;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;
  localparam logic [PROB_W-1:0]     CONF_RESET     = 16'd39321;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 9'd300;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VAD_THRESHOLD        = 3'd0,
    REG_INFERENCE_INTERVAL   = 3'd1,
    REG_CONFIDENCE_THRESHOLD = 3'd2,
    REG_TIMEOUT_FRAMES       = 3'd3
  } cfg_reg_t;

  // One result item
  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] id;
    logic [MODE_W-1:0]  mode;
  } result_t;

endpackage

// File: rtl/core/keyword_detect_controller.sv
// Keyword detect controller: mode machine, smoothing ring and output skid stage.
//
// Each input transfer carries one 10 ms frame summary (energy, top class, top
// probability) and yields exactly one result transfer. All per-frame work is a
// short path from the state registers and the input ports into the state and
// the result register, so one frame is taken every clock cycle while in_ready
// is high. Its result goes into the output register, or into the one-entry
// skid register while the output is stalled: a stalled result does not stop the
// next frame being taken, and in_ready only drops while both are full. The
// mode machine is idle / active / command-ready; in active mode every
// inference_interval-th frame whose probability exceeds confidence_threshold
// pushes its class into a five-entry ring held in flip-flops, and a ring full
// of one class reports that class. The ring is cleared only by reset.
// Configuration writes are accepted every cycle (cfg_ready is always high);
// indexes beyond the last register are ignored, and only the register's width
// of cfg_data is kept. Write configuration only while no frame is in flight.
module keyword_detect_controller
  import kdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // frame summary channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ENERGY_W-1:0]   frame_energy,
  input  logic [CLASS_W-1:0]    top_class,
  input  logic [PROB_W-1:0]     top_prob,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  command_found,
  output logic [CLASS_W-1:0]    command_id,
  output logic [MODE_W-1:0]     mode_now
);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_READY  = 2'd2
  } mode_t;

  // configuration registers
  logic [ENERGY_W-1:0]   vad_threshold;
  logic [INTERVAL_W-1:0] inference_interval;
  logic [PROB_W-1:0]     confidence_threshold;
  logic [TIMEOUT_W-1:0]  timeout_frames;

  // controller state
  mode_t                 mode, mode_next;
  logic [COUNT_W-1:0]    active_count, active_count_next;
  logic [INTERVAL_W-1:0] interval_phase, interval_phase_next;
  logic [ENTRY_W-1:0]    recent_classes [SMOOTH_DEPTH];
  logic [ENTRY_W-1:0]    recent_classes_next [SMOOTH_DEPTH];
  logic [POS_W-1:0]      ring_position, ring_position_next;

  // result path
  result_t               result_new;
  result_t               skid;
  logic                  skid_valid;

  logic                  in_xfer;
  logic                  push;
  logic                  all_same;
  logic [INTERVAL_W-1:0] phase_inc;
  logic [POS_W-1:0]      wr_pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_xfer   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vad_threshold        <= VAD_RESET;
      inference_interval   <= INTERVAL_RESET;
      confidence_threshold <= CONF_RESET;
      timeout_frames       <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_VAD_THRESHOLD:        vad_threshold        <= cfg_data[ENERGY_W-1:0];
        REG_INFERENCE_INTERVAL:   inference_interval   <= cfg_data[INTERVAL_W-1:0];
        REG_CONFIDENCE_THRESHOLD: confidence_threshold <= cfg_data[PROB_W-1:0];
        REG_TIMEOUT_FRAMES:       timeout_frames       <= cfg_data[TIMEOUT_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-frame next state
  // ---------------------------------------------------------------------------
  always_comb begin
    mode_next           = mode;
    active_count_next   = active_count;
    interval_phase_next = interval_phase;
    ring_position_next  = ring_position;
    recent_classes_next = recent_classes;
    push                = 1'b0;
    all_same            = 1'b0;
    phase_inc           = interval_phase + 1'b1;
    // out-of-range position cannot arise, but the ring restarts at 0 if it did
    wr_pos              = (32'(ring_position) >= SMOOTH_DEPTH) ? '0 : ring_position;
    result_new          = '0;

    case (mode)
      MODE_IDLE: begin
        if (frame_energy > vad_threshold) begin
          mode_next           = MODE_ACTIVE;
          active_count_next   = '0;
          interval_phase_next = '0;
        end
      end
      MODE_ACTIVE: begin
        if (active_count != COUNT_MAX) begin
          active_count_next = active_count + 1'b1;
        end
        interval_phase_next = phase_inc;
        // an interval of zero fires on every frame, like one
        if (phase_inc >= inference_interval || phase_inc == '0) begin
          interval_phase_next = '0;
          push = (top_prob > confidence_threshold) &&
                 ({1'b0, top_class} < ENTRY_W'(CLASS_COUNT));
        end
        if (push) begin
          recent_classes_next[wr_pos] = {1'b0, top_class};
          ring_position_next = (32'(wr_pos) == SMOOTH_DEPTH - 1) ? '0 : wr_pos + 1'b1;
          all_same = (recent_classes_next[0] != EMPTY_MARK);
          for (int i = 1; i < SMOOTH_DEPTH; i++) begin
            if (recent_classes_next[i] != recent_classes_next[0]) all_same = 1'b0;
          end
        end
        if (all_same) begin
          mode_next        = MODE_READY;
          result_new.found = 1'b1;
          result_new.id    = recent_classes_next[0][CLASS_W-1:0];
        end else if (active_count_next > {1'b0, timeout_frames}) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_READY: mode_next = MODE_IDLE;
      default:    mode_next = MODE_IDLE;  // stray code: back to idle
    endcase

    result_new.mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      active_count   <= '0;
      interval_phase <= '0;
      ring_position  <= '0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) recent_classes[i] <= EMPTY_MARK;
    end else if (in_xfer) begin
      mode           <= mode_next;
      active_count   <= active_count_next;
      interval_phase <= interval_phase_next;
      ring_position  <= ring_position_next;
      recent_classes <= recent_classes_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output register free this cycle: drain the skid first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        command_found <= skid.found;
        command_id    <= skid.id;
        mode_now      <= skid.mode;
      end else if (in_xfer) begin
        command_found <= result_new.found;
        command_id    <= result_new.id;
        mode_now      <= result_new.mode;
      end
    end else if (in_xfer) begin
      skid <= result_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_found_iff_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (command_found == (mode_now == MODE_READY)))
    else $error("command flag disagrees with reported mode");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !command_found) |-> (command_id == '0))
    else $error("command id non-zero without a command");

  a_ready_to_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode == MODE_READY) |=> (mode == MODE_IDLE))
    else $error("command-ready mode did not return to idle");

endmodule

// File: dv/kdc_result_checker.sv
// Result checker for the keyword detect controller: models each frame and compares results.
module kdc_result_checker
  import kdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [ENERGY_W-1:0]   frame_energy,
  input  logic [CLASS_W-1:0]    top_class,
  input  logic [PROB_W-1:0]     top_prob,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  command_found,
  input  logic [CLASS_W-1:0]    command_id,
  input  logic [MODE_W-1:0]     mode_now,
  output int                    results_due,
  output int                    mismatches
);

  typedef enum logic [MODE_W-1:0] {
    IDLE_MODE   = 2'd0,
    ACTIVE_MODE = 2'd1,
    READY_MODE  = 2'd2
  } kdc_mode_t;

  // register copies
  logic [ENERGY_W-1:0]   vad_thr;
  logic [INTERVAL_W-1:0] infer_every;
  logic [PROB_W-1:0]     conf_thr;
  logic [TIMEOUT_W-1:0]  time_limit;

  // controller state copies
  kdc_mode_t             ctl_mode;
  logic [COUNT_W-1:0]    frames_active;
  logic [INTERVAL_W-1:0] infer_phase;
  logic [ENTRY_W-1:0]    class_ring [SMOOTH_DEPTH];
  int                    ring_pos;

  result_t awaited[$];
  result_t want;
  int      errs = 0;

  assign mismatches = errs;

  // One frame through the mode machine; returns the result it must give.
  function automatic result_t advance_frame(input logic [ENERGY_W-1:0] energy,
                                            input logic [CLASS_W-1:0]  cls,
                                            input logic [PROB_W-1:0]   prob);
    result_t r;
    logic    agree;
    r = '0;
    case (ctl_mode)
      IDLE_MODE: begin
        if (energy > vad_thr) begin
          ctl_mode      = ACTIVE_MODE;
          frames_active = '0;
          infer_phase   = '0;
        end
      end
      ACTIVE_MODE: begin
        if (frames_active != COUNT_MAX) frames_active++;
        infer_phase++;
        // interval of zero acts as one: the wrapped phase always classifies
        if (infer_phase >= infer_every || infer_phase == '0) begin
          infer_phase = '0;
          if (prob > conf_thr && cls < CLASS_COUNT) begin
            class_ring[ring_pos] = ENTRY_W'(cls);
            ring_pos = (ring_pos + 1) % SMOOTH_DEPTH;
            agree = (class_ring[0] != EMPTY_MARK);
            for (int i = 1; i < SMOOTH_DEPTH; i++)
              if (class_ring[i] != class_ring[0]) agree = 1'b0;
            if (agree) begin
              r.found  = 1'b1;
              r.id     = class_ring[0][CLASS_W-1:0];
              ctl_mode = READY_MODE;
            end
          end
        end
        // no timeout on a command frame
        if (!r.found && frames_active > time_limit) ctl_mode = IDLE_MODE;
      end
      default: ctl_mode = IDLE_MODE;
    endcase
    r.mode = ctl_mode;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      vad_thr       = VAD_RESET;
      infer_every   = INTERVAL_RESET;
      conf_thr      = CONF_RESET;
      time_limit    = TIMEOUT_RESET;
      ctl_mode      = IDLE_MODE;
      frames_active = '0;
      infer_phase   = '0;
      ring_pos      = 0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) class_ring[i] = EMPTY_MARK;
      awaited.delete();
      results_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result transfer with nothing awaited: found %0d id %0d mode %0d",
                 command_found, command_id, mode_now);
          errs++;
        end else begin
          want = awaited.pop_front();
          if (command_found !== want.found) begin
            $error("command_found: expected %0d, got %0d", want.found, command_found);
            errs++;
          end
          if (command_id !== want.id) begin
            $error("command_id: expected %0d, got %0d", want.id, command_id);
            errs++;
          end
          if (mode_now !== want.mode) begin
            $error("mode_now: expected %0d, got %0d", want.mode, mode_now);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VAD_THRESHOLD:        vad_thr     = cfg_data[ENERGY_W-1:0];
          REG_INFERENCE_INTERVAL:   infer_every = cfg_data[INTERVAL_W-1:0];
          REG_CONFIDENCE_THRESHOLD: conf_thr    = cfg_data[PROB_W-1:0];
          REG_TIMEOUT_FRAMES:       time_limit  = cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        awaited.push_back(advance_frame(frame_energy, top_class, top_prob));
      results_due <= awaited.size();
    end
  end

endmodule

// File: dv/keyword_detect_controller_tb.sv
// Testbench top for the keyword detect controller: stimulus, idling and verdict.
module keyword_detect_controller_tb;
  import kdc_pkg::*;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [PROB_W-1:0]   PROB_MAX   = '1;
  localparam logic [CLASS_W-1:0]  CLASS_TOP  = '1;
  // directed settings: every frame classified, a short timeout
  localparam logic [PROB_W-1:0]    DIR_CONF    = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] DIR_TIMEOUT = 9'd5;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ENERGY_W-1:0]   frame_energy = '0;
  logic [CLASS_W-1:0]    top_class = '0;
  logic [PROB_W-1:0]     top_prob = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  command_found;
  logic [CLASS_W-1:0]    command_id;
  logic [MODE_W-1:0]     mode_now;

  int results_due;
  int mismatches;

  // settings currently in the block, used to aim the random frames
  logic [ENERGY_W-1:0]   cur_vad   = VAD_RESET;
  logic [INTERVAL_W-1:0] cur_every = INTERVAL_RESET;
  logic [PROB_W-1:0]     cur_conf  = CONF_RESET;

  // quiet stretches: while non-zero, that side neither gaps nor stalls
  int tx_quiet = 0;
  int rx_quiet = 0;
  int rx_hold  = 0;
  int rx_stall;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyword_detect_controller DUT (.*);

  kdc_result_checker watch (.*);

  // Result side: after each transfer, draw a random stall unless quiet. out_ready
  // only changes once per edge, so a stall of zero keeps it high throughout.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      if (rx_quiet > 0) begin
        rx_quiet--;
        rx_stall = 0;
      end else begin
        rx_stall = $urandom_range(0, 19);
        if ($urandom_range(0, 24) == 0) rx_quiet = $urandom_range(20, 80);
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_hold = rx_stall;
      end
    end else if (!out_ready) begin
      if (rx_hold > 1) rx_hold--;
      else out_ready <= 1'b1;
    end
  end

  // One frame transfer. valid is left high on return so that a gapless next
  // frame never lowers and raises it in the same step; it drops only when a
  // gap is drawn or when a run of frames ends.
  task automatic send_frame(input logic [ENERGY_W-1:0] energy,
                            input logic [CLASS_W-1:0]  cls,
                            input logic [PROB_W-1:0]   prob);
    int gap;
    if (tx_quiet > 0) begin
      tx_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 24) == 0) tx_quiet = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    frame_energy <= energy;
    top_class    <= cls;
    top_prob     <= prob;
    do @(posedge clk); while (!in_ready);
  endtask

  // Register write; cfg_valid stays high for a following write in the batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop sending, let every awaited result arrive, then write all registers.
  // Junk above the width of the interval, confidence and timeout registers
  // must be dropped, and a write to an unused index must change nothing.
  task automatic apply_settings(input logic [ENERGY_W-1:0]   vad,
                                input logic [INTERVAL_W-1:0] every,
                                input logic [PROB_W-1:0]     conf,
                                input logic [TIMEOUT_W-1:0]  lim);
    logic [63:0] junk;
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    junk = {$urandom, $urandom};
    write_reg(REG_VAD_THRESHOLD, vad);
    write_reg(REG_INFERENCE_INTERVAL, {junk[CFG_DATA_W-1:INTERVAL_W], every});
    write_reg(REG_CONFIDENCE_THRESHOLD, {junk[CFG_DATA_W-1:PROB_W], conf});
    write_reg(REG_TIMEOUT_FRAMES, {junk[CFG_DATA_W-1:TIMEOUT_W], lim});
    write_reg(CFG_IDX_W'($urandom_range(REG_TIMEOUT_FRAMES + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    cur_vad   = vad;
    cur_every = every;
    cur_conf  = conf;
  endtask

  // Energy that wakes the block (wake set) or stays at or under the threshold.
  function automatic logic [ENERGY_W-1:0] pick_energy(input bit wake);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (wake)
      return (cur_vad == ENERGY_MAX) ? ENERGY_MAX
                                     : ENERGY_W'(cur_vad + 1 + r % (ENERGY_MAX - cur_vad));
    return ENERGY_W'(r % (64'(cur_vad) + 1));
  endfunction

  // Random traffic: mostly a wake frame followed by a run of one class above
  // the confidence threshold, of a random length that may fill the ring at the
  // current interval, with noise frames mixed in; the rest is fully random frames.
  task automatic run_traffic(input int n);
    int                   sent;
    int                   len;
    int                   span;
    logic [CLASS_W-1:0]   cls;
    logic [PROB_W-1:0]    prob;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 7) begin
        cls  = CLASS_W'($urandom);
        span = (cur_every == 0) ? 1 : cur_every;
        len  = $urandom_range(1, 5 * span + 6);
        if (len > 60) len = $urandom_range(20, 60);
        send_frame(pick_energy(1'b1), CLASS_W'($urandom), PROB_W'($urandom));
        sent++;
        for (int k = 0; k < len && sent < n; k++) begin
          if ($urandom_range(0, 7) != 0) begin
            prob = (cur_conf == PROB_MAX) ? PROB_MAX
                                          : PROB_W'(cur_conf + $urandom_range(1, PROB_MAX - cur_conf));
            send_frame(pick_energy(1'b0), cls, prob);
          end else begin
            send_frame(ENERGY_W'({$urandom, $urandom}), CLASS_W'($urandom), PROB_W'($urandom));
          end
          sent++;
        end
      end else begin
        send_frame(ENERGY_W'({$urandom, $urandom}), CLASS_W'($urandom), PROB_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wake threshold at reset values: zero and exactly-at-threshold stay
    // idle, one above wakes.
    send_frame('0, '0, '0);
    send_frame(VAD_RESET, CLASS_TOP, PROB_MAX);
    send_frame(VAD_RESET + 1, '0, PROB_MAX);

    // Block is active here. Classify every frame, short timeout.
    apply_settings(VAD_RESET, 8'd1, DIR_CONF, DIR_TIMEOUT);
    send_frame(ENERGY_MAX, CLASS_TOP, PROB_MAX);
    send_frame('0, 6'd5, DIR_CONF);              // probability equal to threshold: not counted
    repeat (4) send_frame('0, CLASS_TOP, DIR_CONF + 16'd1);
    // that last frame is past the timeout but carries the command
    send_frame('0, '0, '0);                      // command ready falls back to idle
    send_frame(ENERGY_MAX, '0, '0);
    repeat (5) send_frame('0, '0, PROB_MAX);     // overwrite the whole ring with class 0
    send_frame('0, '0, '0);
    send_frame(ENERGY_MAX, '0, '0);
    send_frame('0, '0, PROB_MAX);                // ring kept over idle: instant command
    send_frame('0, '0, '0);
    send_frame(ENERGY_MAX, '0, '0);
    repeat (6) send_frame('0, 6'd7, '0);         // nothing counted: timeout to idle

    // Reset values written back explicitly.
    apply_settings(VAD_RESET, INTERVAL_RESET, CONF_RESET, TIMEOUT_RESET);
    run_traffic(300);
    // Non-zero energy wakes, non-zero prob counts; zero timeout leaves only command frames active.
    apply_settings('0, 8'd1, '0, '0);
    run_traffic(150);
    // Nothing wakes and nothing counts.
    apply_settings(ENERGY_MAX, '1, '1, '1);
    run_traffic(80);
    // Zero interval behaves as one.
    apply_settings(ENERGY_W'({$urandom, $urandom}), '0, PROB_W'($urandom_range(0, 60000)),
                   TIMEOUT_W'($urandom_range(1, 20)));
    run_traffic(200);
    apply_settings(38'd1_000_000, 8'd2, 16'd30000, 9'd40);
    run_traffic(250);
    // Longest interval and timeout: at most two classifications before the timeout.
    apply_settings('0, '1, '0, '1);
    run_traffic(150);
    repeat (5) begin
      apply_settings(ENERGY_W'({$urandom, $urandom} >> $urandom_range(0, 30)),
                     INTERVAL_W'($urandom_range(1, 4)), PROB_W'($urandom_range(0, 60000)),
                     TIMEOUT_W'($urandom_range(4, 511)));
      run_traffic(120);
    end

    // Drain, then wait on for any stray result transfer.
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("keyword_detect_controller_tb: done, clean");
    else
      $display("keyword_detect_controller_tb: done, errors");
    $finish;
  end

  // Watchdog: ends a hung run with errors.
  initial begin
    #2_000_000;
    $display("keyword_detect_controller_tb: done, errors");
    $finish;
  end

endmodule
